@@ rtl/core/lcd_window_pixel_serializer_top_macros.svh @@
// Assertion macros for the display byte serializer.
// Outside synthesis they expand to concurrent assertions; with SYNTH set they vanish.
`ifndef LCD_WINDOW_PIXEL_SERIALIZER_TOP_MACROS_SVH
`define LCD_WINDOW_PIXEL_SERIALIZER_TOP_MACROS_SVH

`ifndef SYNTH
// check on every edge out of reset
`define LCDWPS_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check on every edge, reset included
`define LCDWPS_CHECK_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCDWPS_CHECK(lbl, prop, msg)
`define LCDWPS_CHECK_RST(lbl, prop, msg)
`endif

`endif

@@ rtl/core/lcdwps_pkg.sv @@
package lcdwps_pkg;

	localparam int unsigned PANEL_WIDTH_DEF  = 176;
	localparam int unsigned PANEL_HEIGHT_DEF = 220;

	// panel register commands
	localparam logic [7:0] CMD_HEND   = 8'h37;
	localparam logic [7:0] CMD_HSTART = 8'h36;
	localparam logic [7:0] CMD_VEND   = 8'h39;
	localparam logic [7:0] CMD_VSTART = 8'h38;
	localparam logic [7:0] CMD_ADDRX  = 8'h20;
	localparam logic [7:0] CMD_ADDRY  = 8'h21;
	localparam logic [7:0] CMD_MEMWR  = 8'h22;

	// orientation codes
	localparam logic [1:0] ORIENT_NATIVE = 2'd0;
	localparam logic [1:0] ORIENT_ROT1   = 2'd1;
	localparam logic [1:0] ORIENT_ROT2   = 2'd2;
	localparam logic [1:0] ORIENT_ROT3   = 2'd3;

	localparam logic ACTION_WINDOW = 1'b0;
	localparam logic ACTION_PIXEL  = 1'b1;

	typedef enum logic [2:0] {
		SL_HEND,
		SL_HSTART,
		SL_VEND,
		SL_VSTART,
		SL_ADDRX,
		SL_ADDRY,
		SL_MEMWR
	} slot_t;

	typedef enum logic [1:0] {
		PH_CMD,
		PH_HI,
		PH_LO
	} phase_t;

	typedef struct packed {
		logic        action;
		logic [7:0]  x_start;
		logic [7:0]  y_start;
		logic [7:0]  x_end;
		logic [7:0]  y_end;
		logic [15:0] pixel;
	} item_t;

	typedef struct packed {
		logic       is_data;
		logic [7:0] out_byte;
		logic       last;
	} result_t;

	// position of the serializer inside one transaction
	typedef struct packed {
		slot_t  slot;
		phase_t phase;
	} pos_t;

endpackage

@@ rtl/core/lcd_window_pixel_serializer_top.sv @@
// Display byte serializer: turns window set-up and pixel transactions into a
// tagged byte stream for a panel link.
// Input: present item with start high; it is taken at an edge where busy is
// low. A window item rotates its rectangle by the orientation register and
// yields 19 bytes (six register writes of command, high byte, low byte, then
// the memory-write command); a pixel item yields its colour as two data bytes.
// Output: one byte per cycle on result, marked by strobe for exactly one cycle;
// result.last flags the final byte of a transaction. The receiver cannot stall.
// An accepted item and its position are registered first; its first byte is then
// registered on result with strobe high, from which the receiver takes it.
// Throughput: one byte per cycle, set by the single output byte register; busy
// drops in the cycle before the final byte reaches result, so the next
// transaction follows with no gap.
// Configuration: cfg_data is written to the orientation register when cfg_valid
// is high (cfg_ready is always high); write it only while the block is idle.
// Reset: asynchronous, active low; the stream stops and orientation returns to
// native.
module lcd_window_pixel_serializer_top #(
	parameter int unsigned PANEL_WIDTH  = lcdwps_pkg::PANEL_WIDTH_DEF,
	parameter int unsigned PANEL_HEIGHT = lcdwps_pkg::PANEL_HEIGHT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lcdwps_pkg::item_t   item,
	output logic                strobe,
	output lcdwps_pkg::result_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_data
);

	`include "lcd_window_pixel_serializer_top_macros.svh"

	lcdwps_pkg::item_t   item_q;
	lcdwps_pkg::result_t res_q;
	lcdwps_pkg::result_t res_next;
	lcdwps_pkg::pos_t    pos;
	lcdwps_pkg::slot_t   slot_q;
	lcdwps_pkg::phase_t  phase_q;
	logic                active_q;
	logic                strobe_q;
	logic [1:0]          orient_q;
	logic                last_now;
	logic                accept;

	assign cfg_ready = 1'b1;

	assign pos.slot  = slot_q;
	assign pos.phase = phase_q;

	always_comb begin
		if (item_q.action == lcdwps_pkg::ACTION_PIXEL) begin
			last_now = (phase_q == lcdwps_pkg::PH_LO);
		end else begin
			last_now = (slot_q == lcdwps_pkg::SL_MEMWR);
		end
	end

	// free up during the final byte so the next transaction follows directly
	assign busy   = active_q && !last_now;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_q <= lcdwps_pkg::ORIENT_NATIVE;
		end else if (cfg_valid && cfg_ready) begin
			orient_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			slot_q   <= lcdwps_pkg::SL_HEND;
			phase_q  <= lcdwps_pkg::PH_CMD;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (accept) begin
				active_q <= 1'b1;
				slot_q   <= lcdwps_pkg::SL_HEND;
				// a pixel skips the command phase
				phase_q  <= (item.action == lcdwps_pkg::ACTION_PIXEL) ?
					lcdwps_pkg::PH_HI : lcdwps_pkg::PH_CMD;
			end else if (active_q && last_now) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				if (phase_q == lcdwps_pkg::PH_LO) begin
					phase_q <= lcdwps_pkg::PH_CMD;
					slot_q  <= lcdwps_pkg::slot_t'(slot_q + 3'd1);
				end else begin
					phase_q <= lcdwps_pkg::phase_t'(phase_q + 2'd1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (active_q) begin
			res_q <= res_next;
		end
	end

	lcdwps_map #(
		.PANEL_WIDTH (PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT)
	) u_map (
		.item       (item_q),
		.orientation(orient_q),
		.pos        (pos),
		.result     (res_next)
	);

	assign strobe = strobe_q;
	assign result = res_q;

	`LCDWPS_CHECK(a_accept_then_byte, (start && !busy) |=> ##1 strobe, "accepted item gave no byte")
	`LCDWPS_CHECK(a_no_gap, (strobe && !result.last) |=> strobe, "gap inside a transaction")
	`LCDWPS_CHECK(a_last_cmd_memwr, (strobe && !result.is_data && result.last) |-> (result.out_byte == lcdwps_pkg::CMD_MEMWR), "final command byte is not memory write")
	`LCDWPS_CHECK_RST(a_reset_quiet, !arst_n |-> !strobe, "strobe during reset")

endmodule

@@ rtl/core/lcdwps_map.sv @@
module lcdwps_map #(
	parameter int unsigned PANEL_WIDTH  = lcdwps_pkg::PANEL_WIDTH_DEF,
	parameter int unsigned PANEL_HEIGHT = lcdwps_pkg::PANEL_HEIGHT_DEF
) (
	input  lcdwps_pkg::item_t   item,
	input  logic [1:0]          orientation,
	input  lcdwps_pkg::pos_t    pos,
	output lcdwps_pkg::result_t result
);

	localparam logic [15:0] WM1 = 16'(PANEL_WIDTH - 1);
	localparam logic [15:0] HM1 = 16'(PANEL_HEIGHT - 1);

	logic [15:0] xs, ys, xe, ye;
	logic [15:0] nx1, nx2, ny1, ny2, cx, cy;
	logic [15:0] value;
	logic [7:0]  cmd;

	assign xs = {8'h00, item.x_start};
	assign ys = {8'h00, item.y_start};
	assign xe = {8'h00, item.x_end};
	assign ye = {8'h00, item.y_end};

	// rotate the window into panel coordinates, subtractions wrap at 16 bits
	always_comb begin
		unique case (orientation)
			lcdwps_pkg::ORIENT_ROT1: begin
				nx1 = WM1 - ye;
				nx2 = WM1 - ys;
				ny1 = xs;
				ny2 = xe;
				cx  = WM1 - ys;
				cy  = xs;
			end
			lcdwps_pkg::ORIENT_ROT2: begin
				nx1 = WM1 - xe;
				nx2 = WM1 - xs;
				ny1 = HM1 - ye;
				ny2 = HM1 - ys;
				cx  = WM1 - xs;
				cy  = HM1 - ys;
			end
			lcdwps_pkg::ORIENT_ROT3: begin
				nx1 = ys;
				nx2 = ye;
				ny1 = HM1 - xe;
				ny2 = HM1 - xs;
				cx  = ys;
				cy  = HM1 - xs;
			end
			default: begin
				nx1 = xs;
				nx2 = xe;
				ny1 = ys;
				ny2 = ye;
				cx  = xs;
				cy  = ys;
			end
		endcase
	end

	always_comb begin
		unique case (pos.slot)
			lcdwps_pkg::SL_HEND: begin
				cmd   = lcdwps_pkg::CMD_HEND;
				value = nx1;
			end
			lcdwps_pkg::SL_HSTART: begin
				cmd   = lcdwps_pkg::CMD_HSTART;
				value = nx2;
			end
			lcdwps_pkg::SL_VEND: begin
				cmd   = lcdwps_pkg::CMD_VEND;
				value = ny1;
			end
			lcdwps_pkg::SL_VSTART: begin
				cmd   = lcdwps_pkg::CMD_VSTART;
				value = ny2;
			end
			lcdwps_pkg::SL_ADDRX: begin
				cmd   = lcdwps_pkg::CMD_ADDRX;
				value = cx;
			end
			lcdwps_pkg::SL_ADDRY: begin
				cmd   = lcdwps_pkg::CMD_ADDRY;
				value = cy;
			end
			default: begin
				cmd   = lcdwps_pkg::CMD_MEMWR;
				value = 16'h0000;
			end
		endcase
	end

	// pixel bytes come straight from the colour, window bytes from the slot
	always_comb begin
		if (item.action == lcdwps_pkg::ACTION_PIXEL) begin
			result.is_data  = 1'b1;
			result.out_byte = (pos.phase == lcdwps_pkg::PH_LO) ? item.pixel[7:0] : item.pixel[15:8];
			result.last     = (pos.phase == lcdwps_pkg::PH_LO);
		end else begin
			unique case (pos.phase)
				lcdwps_pkg::PH_HI: begin
					result.is_data  = 1'b1;
					result.out_byte = value[15:8];
				end
				lcdwps_pkg::PH_LO: begin
					result.is_data  = 1'b1;
					result.out_byte = value[7:0];
				end
				default: begin
					result.is_data  = 1'b0;
					result.out_byte = cmd;
				end
			endcase
			result.last = (pos.slot == lcdwps_pkg::SL_MEMWR);
		end
	end

endmodule
